[rtl/core/pkdeg_pkg.sv]
package pkdeg_pkg;

    localparam int NUM_KEYS   = 256;
    localparam int ADDR_W     = $clog2(NUM_KEYS);
    localparam int KEY_W      = 8;
    localparam int CNT_W      = 8;
    localparam int STEPS_W    = 7;
    localparam int LIMIT_W    = 8;
    localparam int CFG_W      = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_STEPS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_ENABLED = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SETUP_MODE     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_NOISE_LIMIT    = 2'd3;

    localparam logic [STEPS_W-1:0] STEPS_RESET = 7'd4;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd100;

    localparam logic signed [CNT_W-1:0] CNT_RELEASED = -8'sd1;
    localparam logic signed [CNT_W-1:0] CNT_PRESSED  = 8'sd1;
    localparam logic [CNT_W-1:0]        THR_MAX      = 8'd127;
    localparam logic [CNT_W-1:0]        NOISE_MAX    = 8'hff;
    localparam logic [KEY_W:0]          NUM_KEYS_EXT = (KEY_W+1)'(NUM_KEYS);

    typedef struct packed {
        logic [STEPS_W-1:0] debounce_steps;
        logic               output_enabled;
        logic               setup_mode;
        logic [LIMIT_W-1:0] noise_limit;
    } cfg_t;

    typedef struct packed {
        logic                    noisy;
        logic signed [CNT_W-1:0] count;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);
    localparam entry_t ENTRY_RESET = '{noisy: 1'b0, count: CNT_RELEASED};

    typedef struct packed {
        logic             event_valid;
        logic             event_release;
        logic [KEY_W-1:0] event_key;
        logic             event_to_control;
        logic [CNT_W-1:0] noise_total;
    } result_t;

endpackage

[rtl/core/per_key_debounce_event_generator_unit.sv]
// channel | handshake            | payload
// --------+----------------------+--------------------------------------------
// in      | in_valid / in_stall  | key_index, key_off
// out     | out_valid / out_stall| event_valid, event_release, event_key,
//         |                      | event_to_control, noise_total
// cfg     | cfg_we               | cfg_index, cfg_data
//
// One item per cycle sustained while in_stall is low.
// The streak RAM read (registered) sets the first stage; the update
// and write-back happen in the second, with a bypass for back-to-back hits.
// Reset clears control state and marks every key as never written (reads -1).
// in_stall rises only when the 4-entry result queue plus the item in flight
// would overflow; a stalled output holds its item.
module per_key_debounce_event_generator_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [pkdeg_pkg::KEY_W-1:0]     key_index,
    input  logic                             key_off,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic                             event_valid,
    output logic                             event_release,
    output logic [pkdeg_pkg::KEY_W-1:0]     event_key,
    output logic                             event_to_control,
    output logic [pkdeg_pkg::CNT_W-1:0]     noise_total,
    input  logic                             cfg_we,
    input  logic [pkdeg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pkdeg_pkg::CFG_W-1:0]     cfg_data
);
    import pkdeg_pkg::*;

    cfg_t                cfg_reg;
    logic                in_acc;
    logic                res_valid;
    result_t             res;
    result_t             head;
    logic [OUTQ_PTR_W:0] q_count;
    logic [OUTQ_PTR_W:0] q_used;
    logic                pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_steps <= STEPS_RESET;
            cfg_reg.output_enabled <= 1'b0;
            cfg_reg.setup_mode     <= 1'b0;
            cfg_reg.noise_limit    <= LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_DEBOUNCE_STEPS: cfg_reg.debounce_steps <= cfg_data[STEPS_W-1:0];
                REG_OUTPUT_ENABLED: cfg_reg.output_enabled <= cfg_data[0];
                REG_SETUP_MODE:     cfg_reg.setup_mode     <= cfg_data[0];
                REG_NOISE_LIMIT:    cfg_reg.noise_limit    <= cfg_data[LIMIT_W-1:0];
            endcase
        end
    end

    // reserve a queue slot for the item still in the update stage
    assign q_used   = q_count + {{OUTQ_PTR_W{1'b0}}, res_valid};
    assign in_stall = (q_used >= (OUTQ_PTR_W+1)'(OUTQ_DEPTH));
    assign in_acc   = in_valid && !in_stall;

    pkdeg_update u_update (
        .clk       (clk),
        .rst_n     (rst_n),
        .acc       (in_acc),
        .key_index (key_index),
        .key_off   (key_off),
        .cfg       (cfg_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    assign out_valid = (q_count != '0);
    assign pop       = out_valid && !out_stall;

    pkdeg_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .pop       (pop),
        .count     (q_count),
        .head      (head)
    );

    assign event_valid      = head.event_valid;
    assign event_release    = head.event_release;
    assign event_key        = head.event_key;
    assign event_to_control = head.event_to_control;
    assign noise_total      = head.noise_total;

endmodule

[rtl/core/pkdeg_ram.sv]
module pkdeg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // read-first: a same-cycle write is not seen by the read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/pkdeg_update.sv]
module pkdeg_update (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      acc,
    input  logic [pkdeg_pkg::KEY_W-1:0] key_index,
    input  logic                      key_off,
    input  pkdeg_pkg::cfg_t           cfg,
    output logic                      res_valid,
    output pkdeg_pkg::result_t        res
);
    import pkdeg_pkg::*;

    logic                 s1_vld_reg;
    logic                 s1_vld_next;
    logic [KEY_W-1:0]     s1_key_reg;
    logic                 s1_off_reg;
    logic                 s1_inrange_reg;
    logic [ADDR_W-1:0]    s1_addr;

    logic                 fwd_vld_reg;
    logic [ADDR_W-1:0]    fwd_addr_reg;
    entry_t               fwd_data_reg;

    logic [NUM_KEYS-1:0]  init_reg;
    logic [CNT_W-1:0]     noise_reg;
    logic [CNT_W-1:0]     noise_next;

    logic [ENTRY_W-1:0]   rdata;
    entry_t               cur;
    entry_t               upd;
    logic                 wr_en;
    logic                 fire;
    logic                 ev;
    logic [CNT_W-1:0]     thr;
    logic signed [CNT_W:0] c_ext;
    logic signed [CNT_W:0] c_inc;
    logic signed [CNT_W:0] c_dec;
    logic signed [CNT_W:0] thr_ext;

    pkdeg_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_KEYS)
    ) u_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (s1_addr),
        .wdata (upd),
        .raddr (key_index[ADDR_W-1:0]),
        .rdata (rdata)
    );

    assign s1_vld_next = acc;
    assign s1_addr     = s1_key_reg[ADDR_W-1:0];
    assign wr_en       = s1_vld_reg && s1_inrange_reg;

    // previous item's write lands on the same edge as this item's read
    always_comb
    begin
        if (fwd_vld_reg && (fwd_addr_reg == s1_addr))
            cur = fwd_data_reg;
        else if (init_reg[s1_addr])
            cur = entry_t'(rdata);
        else
            cur = ENTRY_RESET;
    end

    assign thr     = (cfg.debounce_steps == {STEPS_W{1'b1}}) ? THR_MAX
                   : {1'b0, cfg.debounce_steps} + 8'd1;
    assign thr_ext = $signed({1'b0, thr});
    assign c_ext   = {cur.count[CNT_W-1], cur.count};
    assign c_inc   = c_ext + 9'sd1;
    assign c_dec   = c_ext - 9'sd1;

    always_comb
    begin
        fire      = 1'b0;
        upd.noisy = cur.noisy;
        upd.count = cur.count;
        if (s1_off_reg)
        begin
            if (c_ext <= 9'sd0)
                upd.count = CNT_RELEASED;
            else if (c_inc >= thr_ext)
            begin
                upd.count = CNT_RELEASED;
                fire      = 1'b1;
            end
            else
                upd.count = c_inc[CNT_W-1:0];
        end
        else
        begin
            if (c_ext > 9'sd0)
                upd.count = CNT_PRESSED;
            else if (c_dec <= -thr_ext)
            begin
                upd.count = CNT_PRESSED;
                fire      = 1'b1;
            end
            else
                upd.count = c_dec[CNT_W-1:0];
        end

        noise_next = noise_reg;
        if (wr_en && fire && !cfg.output_enabled && (noise_reg <= cfg.noise_limit))
        begin
            upd.noisy = 1'b1;
            if (noise_reg != NOISE_MAX)
                noise_next = noise_reg + 8'd1;
        end
    end

    assign ev = wr_en && fire && cfg.output_enabled;

    always_comb
    begin
        res.event_valid      = ev;
        res.event_release    = ev && s1_off_reg;
        res.event_key        = ev ? s1_key_reg : '0;
        res.event_to_control = ev && cfg.setup_mode;
        res.noise_total      = noise_next;
    end

    assign res_valid = s1_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            fwd_vld_reg <= 1'b0;
            init_reg    <= '0;
            noise_reg   <= '0;
        end
        else
        begin
            s1_vld_reg  <= s1_vld_next;
            fwd_vld_reg <= wr_en;
            noise_reg   <= noise_next;
            if (wr_en)
            begin
                init_reg[s1_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            s1_key_reg     <= key_index;
            s1_off_reg     <= key_off;
            s1_inrange_reg <= ({1'b0, key_index} < NUM_KEYS_EXT);
        end
        if (wr_en)
        begin
            fwd_addr_reg <= s1_addr;
            fwd_data_reg <= upd;
        end
    end

endmodule

[rtl/core/pkdeg_outq.sv]
module pkdeg_outq (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    input  pkdeg_pkg::result_t             push_data,
    input  logic                           pop,
    output logic [pkdeg_pkg::OUTQ_PTR_W:0] count,
    output pkdeg_pkg::result_t             head
);
    import pkdeg_pkg::*;

    result_t               slot_reg [OUTQ_DEPTH];
    logic [OUTQ_PTR_W-1:0] wr_ptr_reg;
    logic [OUTQ_PTR_W-1:0] rd_ptr_reg;
    logic [OUTQ_PTR_W:0]   count_reg;
    logic [OUTQ_PTR_W:0]   count_next;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign count = count_reg;
    assign head  = slot_reg[rd_ptr_reg];

endmodule

[rtl/core/pkdeg_checker.sv]
module pkdeg_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic       event_valid,
    input logic       event_release,
    input logic [7:0] event_key,
    input logic       event_to_control,
    input logic [7:0] noise_total
);

    // an item with no event carries zeroed event fields
    a_quiet_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !event_valid) |->
            (!event_release && !event_to_control && (event_key == 8'd0)))
        else $error("event fields set without an event");

    // stalled item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=>
            (out_valid && $stable(event_valid) && $stable(event_release)
             && $stable(event_key) && $stable(event_to_control)
             && $stable(noise_total)))
        else $error("stalled output item changed");

    // a rising out_valid must trace back to an input taken earlier
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
        else $error("result without a matching input");

    // nothing queued and nothing in flight: input must be open
    a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(!(in_valid && !in_stall)) && !out_valid) |-> !in_stall)
        else $error("input stalled while block is empty");

endmodule

bind per_key_debounce_event_generator_unit pkdeg_checker u_checker (.*);

[test/tb_per_key_debounce_event_generator_unit.sv]
module tb_per_key_debounce_event_generator_unit;

    timeunit 1ns;
    timeprecision 1ps;

    import pkdeg_pkg::*;

    typedef enum logic {ROW_SCAN, ROW_WRITE} row_kind_t;

    typedef struct packed {
        row_kind_t            kind;
        logic [KEY_W-1:0]     key;
        logic                 off;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [CFG_W-1:0]     reg_val;
        logic                 typed;
        result_t              res;
    } stim_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic [KEY_W-1:0]     key_index;
    logic                 key_off;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic                 event_valid;
    logic                 event_release;
    logic [KEY_W-1:0]     event_key;
    logic                 event_to_control;
    logic [CNT_W-1:0]     noise_total;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    // shadow of the register file
    logic [STEPS_W-1:0] steps_q;
    logic               oe_q;
    logic               setup_q;
    logic [LIMIT_W-1:0] limit_q;

    // per-key state as the block should hold it
    logic signed [CNT_W-1:0] key_streak [NUM_KEYS];
    logic [CNT_W-1:0]        noise_count;
    logic [NUM_KEYS-1:0]     noisy_keys;

    result_t   pending_events [$];
    result_t   got_event;
    result_t   want_event;
    stim_row_t stim_rows [$];
    logic [KEY_W-1:0] hot_keys [8];

    int send_pct = 30;
    int recv_pct = 86;
    int mismatch_count = 0;
    int scans_sent = 0;
    int settings_written = 0;
    int events_seen = 0;
    int control_seen = 0;

    per_key_debounce_event_generator_unit i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .key_index        (key_index),
        .key_off          (key_off),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .event_valid      (event_valid),
        .event_release    (event_release),
        .event_key        (event_key),
        .event_to_control (event_to_control),
        .noise_total      (noise_total),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("Timeout with %0d events outstanding", pending_events.size());
        $display("Mismatches found");
        $finish;
    end

    function automatic int fire_threshold();
        int thr;
        thr = int'(steps_q) + 1;
        if (thr > int'(THR_MAX))
            thr = int'(THR_MAX);
        return thr;
    endfunction

    function automatic result_t debounce_scan(input logic [KEY_W-1:0] key, input logic off);
        int      thr;
        int      cnt;
        bit      fire;
        result_t res;
        thr  = fire_threshold();
        cnt  = int'(key_streak[key]);
        fire = 1'b0;
        res  = '0;
        if (off)
        begin
            if (cnt <= 0)
                cnt = -1;
            else
            begin
                cnt++;
                if (cnt >= thr)
                begin
                    cnt  = -1;
                    fire = 1'b1;
                end
            end
        end
        else if (cnt > 0)
            cnt = 1;
        else
        begin
            cnt--;
            if (cnt <= -thr)
            begin
                cnt  = 1;
                fire = 1'b1;
            end
        end
        key_streak[key] = CNT_W'(cnt);
        if (fire)
        begin
            if (!oe_q)
            begin
                // counting stops once the total has passed the limit
                if (noise_count <= limit_q)
                begin
                    if (noise_count != NOISE_MAX)
                        noise_count++;
                    noisy_keys[key] = 1'b1;
                end
            end
            else
            begin
                res.event_valid      = 1'b1;
                res.event_release    = off;
                res.event_key        = key;
                res.event_to_control = setup_q;
            end
        end
        res.noise_total = noise_count;
        return res;
    endfunction

    function automatic result_t mk_event(input logic vld, input logic rel,
                                         input logic [KEY_W-1:0] key, input logic ctl,
                                         input logic [CNT_W-1:0] noise);
        result_t res;
        res.event_valid      = vld;
        res.event_release    = rel;
        res.event_key        = key;
        res.event_to_control = ctl;
        res.noise_total      = noise;
        return res;
    endfunction

    function automatic stim_row_t scan_row(input logic [KEY_W-1:0] key, input logic off);
        stim_row_t row;
        row      = '0;
        row.kind = ROW_SCAN;
        row.key  = key;
        row.off  = off;
        return row;
    endfunction

    function automatic stim_row_t checked_row(input logic [KEY_W-1:0] key, input logic off,
                                              input result_t res);
        stim_row_t row;
        row       = scan_row(key, off);
        row.typed = 1'b1;
        row.res   = res;
        return row;
    endfunction

    function automatic stim_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_W-1:0] val);
        stim_row_t row;
        row         = '0;
        row.kind    = ROW_WRITE;
        row.reg_idx = idx;
        row.reg_val = val;
        return row;
    endfunction

    task automatic send_scan(input logic [KEY_W-1:0] key, input logic off,
                             input logic typed, input result_t typed_res);
        result_t pred;
        while ($urandom_range(0, 99) < send_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        key_index <= key;
        key_off   <= off;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pred = debounce_scan(key, off);
        pending_events.push_back(typed ? typed_res : pred);
        scans_sent++;
    endtask

    // sender holds off until every item has come back
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_DEBOUNCE_STEPS: steps_q = val[STEPS_W-1:0];
            REG_OUTPUT_ENABLED: oe_q    = val[0];
            REG_SETUP_MODE:     setup_q = val[0];
            REG_NOISE_LIMIT:    limit_q = val[LIMIT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input int steps, input int oe, input int setup, input int limit);
        write_reg(REG_DEBOUNCE_STEPS, CFG_W'(steps));
        write_reg(REG_OUTPUT_ENABLED, CFG_W'(oe));
        write_reg(REG_SETUP_MODE, CFG_W'(setup));
        write_reg(REG_NOISE_LIMIT, CFG_W'(limit));
        settings_written++;
    endtask

    // Mostly runs on a few busy keys that push against the current state for
    // about the threshold length, with stray readings mixed in.
    task automatic run_random(input int n);
        int               sent;
        int               len;
        int               thr;
        logic [KEY_W-1:0] key;
        logic             off;
        logic             pressed;
        sent = 0;
        thr  = fire_threshold();
        while (sent < n)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                send_scan(KEY_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0, '0);
                sent++;
            end
            else
            begin
                key     = hot_keys[$urandom_range(0, 7)];
                pressed = key_streak[key] > 0;
                off     = ($urandom_range(0, 3) != 0) ? pressed : !pressed;
                if ($urandom_range(0, 3) == 0)
                    len = $urandom_range(1, 4);
                else
                    len = $urandom_range(thr - 1, thr + 1);
                for (int j = 0; j < len && sent < n; j++)
                begin
                    if ($urandom_range(0, 5) == 0)
                    begin
                        send_scan(KEY_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                                  1'b0, '0);
                        sent++;
                    end
                    send_scan(key, off, 1'b0, '0);
                    sent++;
                end
            end
        end
    endtask

    task automatic check_field(input string field, input int want, input int got);
        if (want != got)
        begin
            $display("%0t ns: %s expected %0d, got %0d", $time, field, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            got_event = mk_event(event_valid, event_release, event_key, event_to_control,
                                 noise_total);
            if (pending_events.size() == 0)
            begin
                $display("%0t ns: unexpected item, expected none, got %h", $time, got_event);
                mismatch_count++;
            end
            else
            begin
                want_event = pending_events.pop_front();
                check_field("event_valid", int'(want_event.event_valid),
                            int'(got_event.event_valid));
                check_field("event_release", int'(want_event.event_release),
                            int'(got_event.event_release));
                check_field("event_key", int'(want_event.event_key),
                            int'(got_event.event_key));
                check_field("event_to_control", int'(want_event.event_to_control),
                            int'(got_event.event_to_control));
                check_field("noise_total", int'(want_event.noise_total),
                            int'(got_event.noise_total));
                if (got_event.event_valid)
                    events_seen++;
                if (got_event.event_to_control)
                    control_seen++;
            end
        end
        out_stall <= ($urandom_range(0, 99) < recv_pct);
    end

    initial
    begin
        int steps;
        int oe;
        int setup;
        int limit;
        int n_items;
        int waited;

        rst_n     = 1'b0;
        in_valid  = 1'b0;
        key_index = '0;
        key_off   = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;

        steps_q     = STEPS_RESET;
        oe_q        = 1'b0;
        setup_q     = 1'b0;
        limit_q     = LIMIT_RESET;
        noise_count = '0;
        noisy_keys  = '0;
        for (int k = 0; k < NUM_KEYS; k++)
            key_streak[k] = CNT_RELEASED;

        hot_keys[0] = '0;
        hot_keys[1] = '1;
        for (int k = 2; k < 8; k++)
            hot_keys[k] = KEY_W'($urandom_range(0, 255));

        // reset values: threshold 5, so four pressed readings from rest fire;
        // output off, noise limit 100
        stim_rows.push_back(checked_row(8'd0, 1'b1,
                                        mk_event(1'b0, 1'b0, 8'd0, 1'b0, 8'd0)));
        stim_rows.push_back(checked_row(8'd255, 1'b0,
                                        mk_event(1'b0, 1'b0, 8'd0, 1'b0, 8'd0)));
        stim_rows.push_back(checked_row(8'd255, 1'b0,
                                        mk_event(1'b0, 1'b0, 8'd0, 1'b0, 8'd0)));
        stim_rows.push_back(checked_row(8'd255, 1'b0,
                                        mk_event(1'b0, 1'b0, 8'd0, 1'b0, 8'd0)));
        stim_rows.push_back(checked_row(8'd255, 1'b0,
                                        mk_event(1'b0, 1'b0, 8'd0, 1'b0, 8'd1)));
        // noise total already past a zero limit: release is dropped
        stim_rows.push_back(reg_row(REG_NOISE_LIMIT, 8'd0));
        stim_rows.push_back(reg_row(REG_DEBOUNCE_STEPS, 8'd1));
        stim_rows.push_back(checked_row(8'd255, 1'b1,
                                        mk_event(1'b0, 1'b0, 8'd0, 1'b0, 8'd1)));
        stim_rows.push_back(reg_row(REG_OUTPUT_ENABLED, 8'd1));
        stim_rows.push_back(checked_row(8'd255, 1'b0,
                                        mk_event(1'b1, 1'b0, 8'd255, 1'b0, 8'd1)));
        stim_rows.push_back(checked_row(8'd255, 1'b1,
                                        mk_event(1'b1, 1'b1, 8'd255, 1'b0, 8'd1)));
        // an agreeing reading in the middle restarts the streak
        stim_rows.push_back(reg_row(REG_DEBOUNCE_STEPS, 8'd2));
        stim_rows.push_back(scan_row(8'd7, 1'b0));
        stim_rows.push_back(scan_row(8'd7, 1'b1));
        stim_rows.push_back(scan_row(8'd7, 1'b0));
        stim_rows.push_back(scan_row(8'd7, 1'b0));
        stim_rows.push_back(scan_row(8'd7, 1'b0));
        stim_rows.push_back(scan_row(8'd128, 1'b0));
        stim_rows.push_back(reg_row(REG_SETUP_MODE, 8'd1));
        stim_rows.push_back(scan_row(8'd7, 1'b1));
        stim_rows.push_back(scan_row(8'd7, 1'b1));
        stim_rows.push_back(scan_row(8'd1, 1'b1));

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        foreach (stim_rows[r])
        begin
            if (stim_rows[r].kind == ROW_WRITE)
            begin
                drain();
                write_reg(stim_rows[r].reg_idx, stim_rows[r].reg_val);
            end
            else
                send_scan(stim_rows[r].key, stim_rows[r].off, stim_rows[r].typed,
                          stim_rows[r].res);
        end

        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0:
                begin
                    steps = $urandom_range(2, 8); oe = 0; setup = 1;
                    limit = $urandom_range(20, 40); n_items = 250;
                end
                1:
                begin
                    steps = 126; oe = 1; setup = 0; limit = 0; n_items = 250;
                end
                2:
                begin
                    // threshold clamps at the top of the counter range
                    steps = 127; oe = 1; setup = 1; limit = 254; n_items = 200;
                end
                3:
                begin
                    steps = $urandom_range(3, 12); oe = 1; setup = $urandom_range(0, 1);
                    limit = $urandom_range(0, 254); n_items = 200;
                end
                default:
                begin
                    // one press or release per flip: drives the noise total to saturation
                    steps = 1; oe = 0; setup = 0; limit = 255; n_items = 700;
                end
            endcase
            if (ph < 2)
            begin
                send_pct = 30;
                recv_pct = 86;
            end
            else if (ph < 4)
            begin
                send_pct = 86;
                recv_pct = 30;
            end
            else
            begin
                send_pct = 0;
                recv_pct = 0;
            end
            drain();
            set_config(steps, oe, setup, limit);
            run_random(n_items);
        end

        in_valid <= 1'b0;
        waited = 0;
        while (pending_events.size() != 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (8) @(posedge clk);
        if (pending_events.size() != 0)
        begin
            $display("%0t ns: %0d items expected, none received", $time,
                     pending_events.size());
            mismatch_count += pending_events.size();
        end

        $display("Sent %0d key readings under %0d full register settings plus directed writes",
                 scans_sent, settings_written);
        $display("Saw %0d events (%0d to control), noise total ended at %0d over %0d keys",
                 events_seen, control_seen, noise_count, $countones(noisy_keys));
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
